// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n low masking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/msps_pkg.sv
// ----------------------------------------------------------------------------
// msps_pkg
// types and constants of the multiplexed servo pulse sequencer
// ----------------------------------------------------------------------------
package msps_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int WIDTH_W      = 16;
    localparam int FRAME_W      = 16;
    localparam int MASK_W       = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [FRAME_W-1:0] RESET_FRAME = 16'd2500;
    localparam logic [WIDTH_W-1:0] RESET_WIDTH = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 1'd1;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [2:0]         channel;
        logic [WIDTH_W-1:0] width;
    } item_t;

    typedef struct packed {
        logic [7:0] pins;
        logic [2:0] active_slot;
        logic       pulse_high;
    } result_t;

endpackage

// File: hdl/msps_ram.sv
// ----------------------------------------------------------------------------
// msps_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module msps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/multiplexed_servo_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_sequencer
// time-multiplexed servo pulse generator, one slot of frame_ticks per channel
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): each beat is either one
//   timer tick or a pulse width write for one channel. Every beat yields
//   exactly one result beat on result_valid / result_stall / result, which
//   shows the line levels for the current tick of the running slot.
//   Configuration (cfg_we / cfg_index / cfg_data) sets frame_ticks and
//   enable_mask; write it only while no beat is in flight.
//   Throughput: one beat per clock while result_stall is low. The width ram
//   read registers at the edge that takes the beat, as does the read stage;
//   the output register loads from the read stage when that stage advances.
//   The width store sits in a ram with one registered read port addressed by
//   the running slot; a write to the slot being read in the same cycle is
//   forwarded. Per-entry valid bits make unwritten entries read as 1000, so
//   no clearing pass is needed after reset.
//   Reset: frame_ticks 2500, all channels disabled, slot 0, tick 0.
//   A stalled result holds; the block keeps taking beats until the read
//   stage behind the output register is also full, then raises item_stall.
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_sequencer
    import msps_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    localparam int SLOT_W = $clog2(CHANNELS);

    // configuration
    logic [FRAME_W-1:0] frame_ticks_reg;
    logic [MASK_W-1:0]  enable_mask_reg;

    // timing state
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [FRAME_W-1:0] tick_reg, tick_next;
    logic [CHANNELS-1:0] wvalid_reg, wvalid_next;

    // read stage
    logic               s1_valid_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [FRAME_W-1:0] s1_tick_reg;
    logic               s1_entry_valid_reg;
    logic               s1_fwd_reg;
    logic [WIDTH_W-1:0] s1_fwd_width_reg;

    // output stage
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic               accept;
    logic               s1_adv;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [WIDTH_W-1:0] ram_rdata;
    logic [FRAME_W:0]   frame_len;
    logic [FRAME_W:0]   tick_inc;
    logic [WIDTH_W-1:0] width_eff;
    logic [FRAME_W:0]   limit;
    logic [31:0]        slot_wide;
    logic               slot_on;
    logic               level;

    assign s1_adv     = !out_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !s1_adv;
    assign accept     = item_valid && !item_stall;

    assign wr_en   = accept && (item.cmd == CMD_WRITE) && (32'(item.channel) < CHANNELS);
    assign wr_addr = SLOT_W'(item.channel);

    msps_ram #(
        .WIDTH (WIDTH_W),
        .DEPTH (CHANNELS)
    ) u_width_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (item.width),
        .re    (accept),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // zero frame length counts as one tick
    assign frame_len = (frame_ticks_reg == '0) ? (FRAME_W+1)'(1)
                                               : {1'b0, frame_ticks_reg};
    assign tick_inc  = {1'b0, tick_reg} + (FRAME_W+1)'(1);

    always_comb
    begin
        slot_next   = slot_reg;
        tick_next   = tick_reg;
        wvalid_next = wvalid_reg;
        if (wr_en)
        begin
            wvalid_next[wr_addr] = 1'b1;
        end
        if (accept && item.cmd == CMD_TICK)
        begin
            if (tick_inc >= frame_len)
            begin
                tick_next = '0;
                slot_next = (32'(slot_reg) == CHANNELS - 1) ? '0
                                                            : slot_reg + SLOT_W'(1);
            end
            else
            begin
                tick_next = tick_inc[FRAME_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ticks_reg <= RESET_FRAME;
            enable_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_TICKS: frame_ticks_reg <= cfg_data[FRAME_W-1:0];
                CFG_ENABLE_MASK: enable_mask_reg <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            tick_reg      <= '0;
            wvalid_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg   <= slot_next;
            tick_reg   <= tick_next;
            wvalid_reg <= wvalid_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // read stage payload; the ram sees the store before this beat's write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg        <= slot_reg;
            s1_tick_reg        <= tick_reg;
            s1_entry_valid_reg <= wvalid_reg[slot_reg];
            s1_fwd_reg         <= wr_en && (wr_addr == slot_reg);
            s1_fwd_width_reg   <= item.width;
        end
    end

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            width_eff = s1_fwd_width_reg;
        end
        else if (s1_entry_valid_reg)
        begin
            width_eff = ram_rdata;
        end
        else
        begin
            width_eff = RESET_WIDTH;
        end
    end

    assign limit     = ({1'b0, width_eff} > frame_len) ? frame_len : {1'b0, width_eff};
    assign slot_wide = 32'(s1_slot_reg);
    // only the first eight slots have an enable bit
    assign slot_on   = (slot_wide < 32'd8) && enable_mask_reg[slot_wide[2:0]];
    assign level     = slot_on && ({1'b0, s1_tick_reg} < limit);

    always_comb
    begin
        out_next.pins        = level ? (8'd1 << slot_wide[2:0]) : 8'd0;
        out_next.active_slot = slot_wide[2:0];
        out_next.pulse_high  = level;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ASSERT_ALWAYS(a_slot_range, 32'(slot_reg) < CHANNELS,
        "slot index out of range")
    `ASSERT_IMPLIES(a_pins_onehot, result_valid && result.pulse_high, $onehot(result.pins),
        "high pulse without exactly one line")
    `ASSERT_IMPLIES(a_pins_low, result_valid && !result.pulse_high, result.pins == 8'd0,
        "line high outside the pulse")
    `ASSERT_NEXT(a_read_hold, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(ram_rdata) && $stable(s1_slot_reg),
        "read stage lost its data while held")
    `ASSERT_NEXT(a_write_no_time, accept && item.cmd == CMD_WRITE,
        $stable(tick_reg) && $stable(slot_reg),
        "width write advanced time")

endmodule
